// ===== hw/rtl/rc5tx_pkg.sv =====
// rc5tx_pkg: shared types, field widths, register indexes and frame packing
// for the rc5 infrared frame transmitter
// no dependencies
package rc5tx_pkg;

    localparam int ADDR_W     = 5;
    localparam int CMD_W      = 7;
    localparam int EXT_W      = 6;
    localparam int RPT_W      = 4;
    localparam int FRAME_W    = 20;
    localparam int POS_W      = 5;
    localparam int HALF_W     = 16;
    localparam int PAUSE_W    = 18;
    localparam int GAP_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_PAUSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP = 2'd2;

    // register reset values
    localparam logic [HALF_W-1:0]  HALF_BIT_RST   = 16'd889;
    localparam logic [PAUSE_W-1:0] EXT_PAUSE_RST  = 18'd3556;
    localparam logic [GAP_W-1:0]   REPEAT_GAP_RST = 24'd100000;

    // bit positions inside the frame
    localparam logic [POS_W-1:0] TOP_STD   = 5'd13;
    localparam logic [POS_W-1:0] TOP_EXT   = 5'd19;
    localparam logic [POS_W-1:0] POS_PAUSE = 5'd12;
    localparam logic [POS_W-1:0] POS_AFTER = 5'd11;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
        logic [EXT_W-1:0]  extension;
        logic              extended_frame;
        logic [RPT_W-1:0]  repeat_count;
    } t_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic request_rejected;
        logic transmission_done;
    } t_result;

    typedef struct packed {
        logic [HALF_W-1:0]  half_bit_ticks;
        logic [PAUSE_W-1:0] ext_pause_ticks;
        logic [GAP_W-1:0]   repeat_gap_ticks;
    } t_cfg;

    // start, field (inverted command bit 6), toggle, address, command, extension
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [ADDR_W-1:0] address,
        input logic [CMD_W-1:0]  command,
        input logic [EXT_W-1:0]  extension,
        input logic              toggle,
        input logic              extended
    );
        logic field;
        field = ~command[CMD_W-1];
        if (extended) begin
            return {1'b1, field, toggle, address, command[CMD_W-2:0], extension};
        end else begin
            return {6'b0, 1'b1, field, toggle, address, command[CMD_W-2:0]};
        end
    endfunction

endpackage

// ===== hw/rtl/rc5tx_cfg_regs.sv =====
// rc5tx_cfg_regs: timing register file written through the config channel
// depends on rc5tx_pkg
module rc5tx_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rc5tx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc5tx_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rc5tx_pkg::t_cfg                     o_cfg
);
    import rc5tx_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks   <= HALF_BIT_RST;
            r_cfg.ext_pause_ticks  <= EXT_PAUSE_RST;
            r_cfg.repeat_gap_ticks <= REPEAT_GAP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_BIT:   r_cfg.half_bit_ticks   <= i_cfg_data[HALF_W-1:0];
                CFG_EXT_PAUSE:  r_cfg.ext_pause_ticks  <= i_cfg_data[PAUSE_W-1:0];
                CFG_REPEAT_GAP: r_cfg.repeat_gap_ticks <= i_cfg_data[GAP_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/rc5tx_engine.sv =====
// rc5tx_engine: frame sequencer state and the per-item update
// depends on rc5tx_pkg
module rc5tx_engine #(
    parameter int COUNTER_WIDTH = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  rc5tx_pkg::t_item    i_item,
    input  rc5tx_pkg::t_cfg     i_cfg,
    output rc5tx_pkg::t_result  o_result
);
    import rc5tx_pkg::*;

    typedef enum logic [1:0] {
        SEG_BITS,
        SEG_PAUSE,
        SEG_GAP
    } t_seg;

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNTER_WIDTH) - 33'd1;

    function automatic logic [COUNTER_WIDTH-1:0] sat_count(input logic [GAP_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH-1:0] : w[COUNTER_WIDTH-1:0];
    endfunction

    logic                     r_active, n_active;
    logic [FRAME_W-1:0]       r_frame, n_frame;
    logic                     r_ext, n_ext;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic                     r_second, n_second;
    t_seg                     r_seg, n_seg;
    logic [COUNTER_WIDTH-1:0] r_remain, n_remain;
    logic [RPT_W-1:0]         r_repeats, n_repeats;
    logic                     r_toggle, n_toggle;

    logic [COUNTER_WIDTH-1:0] w_half;
    logic [COUNTER_WIDTH-1:0] w_remain_dec;
    logic [POS_W-1:0]         w_top;
    logic                     w_level;
    t_result                  w_res;

    // zero half bit runs as one tick
    assign w_half = (i_cfg.half_bit_ticks == '0) ? COUNTER_WIDTH'(1)
                                                 : COUNTER_WIDTH'(i_cfg.half_bit_ticks);
    assign w_remain_dec = (r_remain != '0) ? (r_remain - COUNTER_WIDTH'(1)) : r_remain;
    assign w_top        = r_ext ? TOP_EXT : TOP_STD;
    // manchester: a one is low then high
    assign w_level = r_active && (r_seg == SEG_BITS) &&
                     (r_second ? r_frame[r_pos] : ~r_frame[r_pos]);

    always_comb begin
        n_active  = r_active;
        n_frame   = r_frame;
        n_ext     = r_ext;
        n_pos     = r_pos;
        n_second  = r_second;
        n_seg     = r_seg;
        n_remain  = r_remain;
        n_repeats = r_repeats;
        n_toggle  = r_toggle;
        w_res     = '0;
        if (i_item.op == OP_SEND) begin
            if (r_active) begin
                w_res.request_rejected = 1'b1;
                w_res.busy_res         = 1'b1;
                w_res.pin_level        = w_level;
            end else begin
                n_toggle  = ~r_toggle;
                n_frame   = build_frame(i_item.address, i_item.command, i_item.extension,
                                        ~r_toggle, i_item.extended_frame);
                n_ext     = i_item.extended_frame;
                n_repeats = i_item.repeat_count;
                n_active  = 1'b1;
                n_seg     = SEG_BITS;
                n_pos     = i_item.extended_frame ? TOP_EXT : TOP_STD;
                n_second  = 1'b0;
                n_remain  = w_half;
                w_res.busy_res  = 1'b1;
                // start bit is a one, so the first half is low
                w_res.pin_level = 1'b0;
            end
        end else if (r_active) begin
            w_res.pin_level = w_level;
            w_res.busy_res  = 1'b1;
            n_remain        = w_remain_dec;
            if (w_remain_dec == '0) begin
                unique case (r_seg)
                    SEG_BITS: begin
                        if (!r_second) begin
                            n_second = 1'b1;
                            n_remain = w_half;
                        end else begin
                            n_second = 1'b0;
                            if (r_pos == '0) begin
                                if (r_repeats == '0) begin
                                    n_active = 1'b0;
                                    n_seg    = SEG_BITS;
                                    n_remain = '0;
                                    w_res.transmission_done = 1'b1;
                                end else begin
                                    n_repeats = r_repeats - RPT_W'(1);
                                    if (i_cfg.repeat_gap_ticks != '0) begin
                                        n_seg    = SEG_GAP;
                                        n_remain = sat_count(i_cfg.repeat_gap_ticks);
                                    end else begin
                                        n_seg    = SEG_BITS;
                                        n_pos    = w_top;
                                        n_remain = w_half;
                                    end
                                end
                            end else if (r_ext && (r_pos == POS_PAUSE) &&
                                         (i_cfg.ext_pause_ticks != '0)) begin
                                n_pos    = POS_AFTER;
                                n_seg    = SEG_PAUSE;
                                n_remain = sat_count(GAP_W'(i_cfg.ext_pause_ticks));
                            end else begin
                                n_pos    = r_pos - POS_W'(1);
                                n_remain = w_half;
                            end
                        end
                    end
                    SEG_PAUSE: begin
                        n_seg    = SEG_BITS;
                        n_second = 1'b0;
                        n_remain = w_half;
                    end
                    SEG_GAP: begin
                        n_seg    = SEG_BITS;
                        n_pos    = w_top;
                        n_second = 1'b0;
                        n_remain = w_half;
                    end
                    default: begin
                        n_seg = SEG_BITS;
                    end
                endcase
            end
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_frame   <= '0;
            r_ext     <= 1'b0;
            r_pos     <= '0;
            r_second  <= 1'b0;
            r_seg     <= SEG_BITS;
            r_remain  <= '0;
            r_repeats <= '0;
            r_toggle  <= 1'b0;
        end else if (i_step) begin
            r_active  <= n_active;
            r_frame   <= n_frame;
            r_ext     <= n_ext;
            r_pos     <= n_pos;
            r_second  <= n_second;
            r_seg     <= n_seg;
            r_remain  <= n_remain;
            r_repeats <= n_repeats;
            r_toggle  <= n_toggle;
        end
    end

endmodule

// ===== hw/rtl/rc5_ir_frame_transmitter.sv =====
// rc5_ir_frame_transmitter: top level, input register, frame engine, result register
// depends on rc5tx_pkg, rc5tx_cfg_regs, rc5tx_engine
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | i_in_valid / o_in_stall  | op, address, command, extension,
//          |           |                        | extended_frame, repeat_count
//  out     | source    | o_out_valid / i_out_stall| pin_level, busy_res, request_rejected,
//          |           |                        | transmission_done
//  cfg     | sink      | i_cfg_valid / o_cfg_ready| register index, write data
//
// one beat per clock while i_out_stall is low; a taken beat passes through the input register
// and then the result register onto the out channel, and leaves it while i_out_stall is low
// the frame engine updates all of its state in the cycle the beat leaves the input register
// synchronous active-low reset clears both valids, the engine and the toggle, and loads
// the timing registers with their defaults
// a stalled full result register stops the engine; with the input register full it stalls in
module rc5_ir_frame_transmitter #(
    parameter int COUNTER_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [rc5tx_pkg::ADDR_W-1:0]        i_address,
    input  logic [rc5tx_pkg::CMD_W-1:0]         i_command,
    input  logic [rc5tx_pkg::EXT_W-1:0]         i_extension,
    input  logic                                i_extended_frame,
    input  logic [rc5tx_pkg::RPT_W-1:0]         i_repeat_count,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_pin_level,
    output logic                                o_busy_res,
    output logic                                o_request_rejected,
    output logic                                o_transmission_done,
    // register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rc5tx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc5tx_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rc5tx_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_out_free;
    logic    w_step;
    logic    w_accept;

    // result register can take a new beat when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;
    // the held beat moves through the engine into the result register
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    rc5tx_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rc5tx_engine #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_step;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op             <= i_op;
            r_item.address        <= i_address;
            r_item.command        <= i_command;
            r_item.extension      <= i_extension;
            r_item.extended_frame <= i_extended_frame;
            r_item.repeat_count   <= i_repeat_count;
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_pin_level         = r_result.pin_level;
    assign o_busy_res          = r_result.busy_res;
    assign o_request_rejected  = r_result.request_rejected;
    assign o_transmission_done = r_result.transmission_done;

endmodule

// ===== hw/rtl/rc5tx_checker.sv =====
// rc5tx_checker: port-level assertions for the rc5 frame transmitter
// bound to rc5_ir_frame_transmitter at the end of this file; no other dependencies
module rc5tx_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_pin_level,
    input logic                                o_busy_res,
    input logic                                o_request_rejected,
    input logic                                o_transmission_done
);

    // held result beat stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pin_level) &&
        $stable(o_busy_res) && $stable(o_request_rejected) && $stable(o_transmission_done))
        else $error("result beat changed under stall");

    // input only backs up when the result side is full and stalled
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a rejected request means a transmission is running, and never ends one
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_request_rejected |-> o_busy_res && !o_transmission_done)
        else $error("reject seen while idle or with done");

    // mark level only while transmitting
    a_mark_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pin_level |-> o_busy_res)
        else $error("mark driven while idle");

    // done only on a tick that started busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transmission_done |-> o_busy_res)
        else $error("done without busy");

endmodule

bind rc5_ir_frame_transmitter rc5tx_checker u_rc5tx_checker (.*);
